@@ src/rcg_pkg.sv @@
// ----------------------------------------------------------------------------
// rcg_pkg
// Shared constants, widths and types for the Roberts cross gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W        = 8;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 13;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;

  localparam int RADICAND_W = 17;
  localparam int ROOT_W     = 9;
  localparam int STEP_W     = 4;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MIN    = 11'd2;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MAX    = WIDTH_REG_W'(MAX_WIDTH);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MIN   = 13'd2;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MAX   = HEIGHT_REG_W'(MAX_HEIGHT);

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SQUARE,
    S_ROOT,
    S_DONE
  } rcg_state_t;

endpackage

`default_nettype wire

@@ src/rcg_ram.sv @@
// ----------------------------------------------------------------------------
// rcg_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/rcg_isqrt.sv @@
// ----------------------------------------------------------------------------
// rcg_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcg_isqrt
  import rcg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [RADICAND_W-1:0] radicand,
  output logic                       done,
  output logic      [ROOT_W-1:0]     root_out
);

  logic                  busy;
  logic [RADICAND_W-1:0] rem;
  logic [RADICAND_W-1:0] root;
  logic [STEP_W-1:0]     step;
  logic [RADICAND_W-1:0] bit_val;
  logic [RADICAND_W:0]   trial;
  logic [4:0]            shamt;

  assign shamt    = {4'(ROOT_W - 1) - step, 1'b0};
  assign bit_val  = RADICAND_W'(1) << shamt;
  assign trial    = {1'b0, root} + {1'b0, bit_val};
  assign root_out = root[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      root <= '0;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem  <= rem - trial[RADICAND_W-1:0];
        root <= (root >> 1) + bit_val;
      end else begin
        root <= root >> 1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/roberts_cross_gradient.sv @@
// ----------------------------------------------------------------------------
// roberts_cross_gradient
// Roberts cross gradient magnitude over a raster stream of 8-bit pixels.
// ----------------------------------------------------------------------------
// One pixel is taken at a time. A pixel that yields a magnitude occupies the
// block from acceptance to the next acceptance: the line buffer read, the
// difference and square step, the nine-step bit-serial square root, and the
// load into the output register, which waits while a held magnitude stalls.
// Pixels on row 0 or column 0 skip the root; pixels past a frame end are dropped.
// The output register holds a finished magnitude while the next pixel is
// worked on. The line buffer is a 1024 x 8 RAM, one read and one write per
// pixel; it needs no clearing after reset.
`default_nettype none

module roberts_cross_gradient
  import rcg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // pixel input
  input  wire logic [PIX_W-1:0]  pixel,
  input  wire logic              frame_start,
  input  wire logic              in_valid,
  output logic                   in_stall,
  // gradient output
  output logic      [PIX_W-1:0]  magnitude,
  output logic                   line_end,
  output logic                   frame_end,
  output logic                   out_valid,
  input  wire logic              out_stall,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  rcg_state_t state, state_next;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [WIDTH_REG_W-1:0]  w_use;
  logic [HEIGHT_REG_W-1:0] h_use;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] c_use;
  logic [ROW_W-1:0] r_use;
  logic             ignore_px;
  logic             last_col;
  logic             in_accept;

  logic [PIX_W-1:0] px;
  logic [COL_W-1:0] col;
  logic             emit;
  logic             last_col_q;
  logic             last_row_q;
  logic [PIX_W-1:0] left_pixel;
  logic [PIX_W-1:0] upper_left_pixel;
  logic [PIX_W-1:0] upper;
  logic [PIX_W-1:0] gx;
  logic [PIX_W-1:0] gy;

  logic             rd_en;
  logic             wr_en;
  logic             load_out;
  logic             root_start;
  logic             root_done;
  logic [ROOT_W-1:0] root;
  logic [RADICAND_W-1:0] radicand;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  assign w_use = (image_width < WIDTH_MIN) ? WIDTH_MIN :
                 (image_width > WIDTH_MAX) ? WIDTH_MAX : image_width;
  assign h_use = (image_height < HEIGHT_MIN) ? HEIGHT_MIN :
                 (image_height > HEIGHT_MAX) ? HEIGHT_MAX : image_height;

  // position of the incoming pixel
  assign in_accept = in_valid && !in_stall;
  assign c_use     = frame_start ? '0 : column_count;
  assign r_use     = frame_start ? '0 : row_count;
  assign ignore_px = r_use >= h_use;
  assign last_col  = ({1'b0, c_use} + (COL_W + 1)'(1)) >= w_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept && !ignore_px) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= r_use + ROW_W'(1);
      end else begin
        column_count <= c_use + COL_W'(1);
        row_count    <= r_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && !ignore_px) begin
      px         <= pixel;
      col        <= c_use;
      emit       <= (r_use != '0) && (c_use != '0);
      last_col_q <= last_col;
      last_row_q <= ({1'b0, r_use} + (ROW_W + 1)'(1)) >= {1'b0, h_use};
    end
  end

  // line buffer
  assign rd_en = in_accept && !ignore_px;
  assign wr_en = (state == S_LOOK);

  rcg_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (col),
    .wr_data (px),
    .rd_en   (rd_en),
    .rd_addr (c_use),
    .rd_data (upper)
  );

  // neighbours and differences
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (state == S_LOOK) begin
      left_pixel       <= px;
      upper_left_pixel <= upper;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      gx <= (upper_left_pixel >= px) ? upper_left_pixel - px : px - upper_left_pixel;
      gy <= (upper >= left_pixel) ? upper - left_pixel : left_pixel - upper;
    end
  end

  assign radicand = (RADICAND_W'(gx) * RADICAND_W'(gx)) +
                    (RADICAND_W'(gy) * RADICAND_W'(gy));

  rcg_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root_out (root)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    root_start = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !ignore_px) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = emit ? S_SQUARE : S_IDLE;
      end
      S_SQUARE: begin
        root_start = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      magnitude <= root[ROOT_W-1] ? {PIX_W{1'b1}} : root[PIX_W-1:0];
      line_end  <= last_col_q;
      frame_end <= last_col_q && last_row_q;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for roberts_cross_gradient. Pixel frames are driven in bursts with
// random gaps while the output side stalls on its own pattern. A predictor
// with its own line memory and neighbour registers computes each expected
// gradient transaction, and every output transaction is checked field by field.
// The frame geometry registers are programmed and read back over the APB port
// between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import rcg_pkg::*;
;

  localparam int unsigned RANDOM_ITEMS  = 450;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned TIMEOUT       = 2000000;

  localparam logic [ADDR_W-1:0] WIDTH_ADDR  = {REG_IMAGE_WIDTH, 2'b00};
  localparam logic [ADDR_W-1:0] HEIGHT_ADDR = {REG_IMAGE_HEIGHT, 2'b00};

  typedef enum {MIX_RANDOM, MIX_EXTREME, MIX_SMOOTH} pixel_mix_t;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic             line_end;
    logic             frame_end;
  } gradient_t;

  logic              clk;
  logic              rst;
  logic [PIX_W-1:0]  pixel;
  logic              frame_start;
  logic              in_valid;
  logic              in_stall;
  logic [PIX_W-1:0]  magnitude;
  logic              line_end;
  logic              frame_end;
  logic              out_valid;
  logic              out_stall;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  roberts_cross_gradient DUT (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .frame_start (frame_start),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .magnitude   (magnitude),
    .line_end    (line_end),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // predictor state
  logic [PIX_W-1:0]        line_mem [MAX_WIDTH];
  logic [PIX_W-1:0]        left_q = '0;
  logic [PIX_W-1:0]        upleft_q = '0;
  int unsigned             col_q = 0;
  int unsigned             row_q = 0;
  logic [WIDTH_REG_W-1:0]  width_reg = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
  gradient_t               gradient_q [$];

  int unsigned errors = 0;
  int unsigned pixels_used = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // returns 1 when the pixel is consumed by the frame, 0 when it is ignored
  function automatic bit predict_pixel(logic [PIX_W-1:0] px, logic first);
    int unsigned w, h, c, r, gx, gy, sum, root;
    logic [PIX_W-1:0] upper;
    bit last;
    gradient_t g;
    w = clamp_dim(width_reg, 2, MAX_WIDTH);
    h = clamp_dim(height_reg, 2, MAX_HEIGHT);
    if (first) begin
      col_q = 0;
      row_q = 0;
    end
    c = col_q;
    r = row_q;
    if (r >= h) return 0;
    upper = line_mem[c];
    last = (c + 1 >= w);
    if (r >= 1 && c >= 1) begin
      gx = (upleft_q > px) ? upleft_q - px : px - upleft_q;
      gy = (upper > left_q) ? upper - left_q : left_q - upper;
      sum = gx * gx + gy * gy;
      root = 0;
      while ((root + 1) * (root + 1) <= sum) root++;
      g.magnitude = (root > 255) ? 8'd255 : PIX_W'(root);
      g.line_end = last;
      g.frame_end = last && (r + 1 >= h);
      gradient_q.push_back(g);
    end
    upleft_q = upper;
    left_q = px;
    line_mem[c] = px;
    if (last) begin
      col_q = 0;
      row_q = r + 1;
    end else begin
      col_q = c + 1;
    end
    return 1;
  endfunction

  task automatic check_value(input string what, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    gradient_t want;
    if (!rst && out_valid && !out_stall) begin
      if (gradient_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual magnitude %0d",
                 $time, magnitude);
        errors++;
      end else begin
        want = gradient_q.pop_front();
        check_value("magnitude", DATA_W'(want.magnitude), DATA_W'(magnitude));
        check_value("line_end", DATA_W'(want.line_end), DATA_W'(line_end));
        check_value("frame_end", DATA_W'(want.frame_end), DATA_W'(frame_end));
      end
    end
  end

  // output stall pattern
  initial begin
    int unsigned busy_pct;
    out_stall = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0: busy_pct = 0;
        1: busy_pct = 25;
        2: busy_pct = 50;
        default: busy_pct = 80;
      endcase
      repeat ($urandom_range(10, 60)) begin
        @(negedge clk);
        out_stall <= ($urandom_range(0, 99) < busy_pct);
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic first);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    while (gap_left != 0) begin
      in_valid <= 1'b0;
      @(negedge clk);
      gap_left--;
    end
    pixel <= px;
    frame_start <= first;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (predict_pixel(px, first)) pixels_used++;
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(pixel_mix_t mix);
    case (mix)
      MIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      MIX_SMOOTH:  return PIX_W'(120 + $urandom_range(0, 15));
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input int unsigned count, input pixel_mix_t mix);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(mix), i == 0);
  endtask

  // stop sending and let every pending transaction drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (gradient_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_geometry();
    logic [DATA_W-1:0] got;
    apb_access(1'b0, WIDTH_ADDR, '0, got);
    check_value("image_width readback", DATA_W'(width_reg), got);
    apb_access(1'b0, HEIGHT_ADDR, '0, got);
    check_value("image_height readback", DATA_W'(height_reg), got);
  endtask

  // upper data bits are random and must be dropped by the registers
  task automatic program_geometry(input int unsigned wv, input int unsigned hv);
    logic [DATA_W-1:0] unused;
    logic [DATA_W-1:0] data;
    data = {21'($urandom), WIDTH_REG_W'(wv)};
    apb_access(1'b1, WIDTH_ADDR, data, unused);
    width_reg = data[WIDTH_REG_W-1:0];
    data = {19'($urandom), HEIGHT_REG_W'(hv)};
    apb_access(1'b1, HEIGHT_ADDR, data, unused);
    height_reg = data[HEIGHT_REG_W-1:0];
    check_geometry();
  endtask

  task automatic test_reset_geometry();
    check_geometry();
    send_frame(8, MIX_RANDOM);
  endtask

  task automatic test_widest_line();
    wait_idle();
    program_geometry(2047, 2);
    send_frame(8, MIX_RANDOM);
  endtask

  task automatic test_corner_cases();
    logic [PIX_W-1:0] grid [9] = '{8'd255, 8'd255, 8'd0,
                                   8'd0,   8'd0,   8'd255,
                                   8'd17,  8'd200, 8'd99};
    wait_idle();
    program_geometry(3, 3);
    foreach (grid[i]) send_pixel(grid[i], i == 0);
    // past the last row, ignored until the next frame start
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd1, 1'b0);
    // a short frame that is cut off in the middle of row 1 by a restart
    for (int i = 0; i < 4; i++) send_pixel(grid[8 - i], i == 0);
    send_frame(9, MIX_EXTREME);
    wait_idle();
    program_geometry(0, 1);
    send_pixel(8'd3, 1'b1);
    send_pixel(8'd4, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    wait_idle();
    program_geometry(2, 8191);
    send_frame(6, MIX_RANDOM);
  endtask

  task automatic test_width_shrink();
    wait_idle();
    program_geometry(8, 4);
    send_frame(14, MIX_RANDOM);
    wait_idle();
    program_geometry(4, 4);
    repeat (9) send_pixel(pick_pixel(MIX_RANDOM), 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned start_used, wv, hv, rows, count;
    start_used = pixels_used;
    while (pixels_used - start_used < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: wv = $urandom_range(0, 1);
        1: wv = $urandom_range(13, 48);
        default: wv = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 9))
        0: hv = $urandom_range(0, 1);
        1: hv = $urandom_range(4097, 8191);
        default: hv = $urandom_range(2, 6);
      endcase
      program_geometry(wv, hv);
      rows = clamp_dim(clamp_dim(hv, 2, MAX_HEIGHT), 2, 6);
      repeat ($urandom_range(1, 3)) begin
        count = clamp_dim(wv, 2, MAX_WIDTH) * rows;
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
        send_frame(count, pixel_mix_t'($urandom_range(0, 2)));
        repeat ($urandom_range(0, 2)) send_pixel(pick_pixel(MIX_RANDOM), 1'b0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    pixel = '0;
    frame_start = 1'b0;
    in_valid = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_geometry();
    test_widest_line();
    test_corner_cases();
    test_width_shrink();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ roberts_cross_gradient.f @@
src/rcg_pkg.sv
src/rcg_ram.sv
src/rcg_isqrt.sv
src/roberts_cross_gradient.sv
tb/tb.sv
